// ----- rtl/plp_pkg.sv -----
// Package for the sync/length/XOR packet parser.
// Holds register indexes, phase, kind and error codes, and shared structs.
// No dependencies.
package plp_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned PHASE_W = 3;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned ADDR_W  = 3;

    // configuration register indexes
    localparam logic [ADDR_W-1:0] REG_SYNC_FIRST  = 3'd0;
    localparam logic [ADDR_W-1:0] REG_SYNC_SECOND = 3'd1;
    localparam logic [ADDR_W-1:0] REG_SYNC_THIRD  = 3'd2;
    localparam logic [ADDR_W-1:0] REG_LENGTH_MIN  = 3'd3;
    localparam logic [ADDR_W-1:0] REG_LENGTH_MAX  = 3'd4;
    localparam logic [ADDR_W-1:0] REG_OVERHEAD    = 3'd5;

    // parse phases
    localparam logic [PHASE_W-1:0] PH_SYNC1 = 3'd0;
    localparam logic [PHASE_W-1:0] PH_SYNC2 = 3'd1;
    localparam logic [PHASE_W-1:0] PH_SYNC3 = 3'd2;
    localparam logic [PHASE_W-1:0] PH_LEN   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DATA  = 3'd4;
    localparam logic [PHASE_W-1:0] PH_CHECK = 3'd5;
    localparam logic [PHASE_W-1:0] PH_HUNT  = 3'd6;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_GOOD    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd2;

    // error codes
    localparam logic [BYTE_W-1:0] ERR_SYNC1 = 8'd0;
    localparam logic [BYTE_W-1:0] ERR_SYNC2 = 8'd1;
    localparam logic [BYTE_W-1:0] ERR_SYNC3 = 8'd2;
    localparam logic [BYTE_W-1:0] ERR_SIZE  = 8'd3;
    localparam logic [BYTE_W-1:0] ERR_CHECK = 8'd4;

    // register reset values
    localparam logic [BYTE_W-1:0] RST_SYNC_FIRST  = 8'd170;
    localparam logic [BYTE_W-1:0] RST_SYNC_SECOND = 8'd85;
    localparam logic [BYTE_W-1:0] RST_SYNC_THIRD  = 8'd204;
    localparam logic [BYTE_W-1:0] RST_LENGTH_MIN  = 8'd8;
    localparam logic [BYTE_W-1:0] RST_LENGTH_MAX  = 8'd255;
    localparam logic [BYTE_W-1:0] RST_OVERHEAD    = 8'd4;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_first;
        logic [BYTE_W-1:0] sync_second;
        logic [BYTE_W-1:0] sync_third;
        logic [BYTE_W-1:0] length_min;
        logic [BYTE_W-1:0] length_max;
        logic [BYTE_W-1:0] overhead_bytes;
    } t_cfg;

    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] item_kind;
        logic [BYTE_W-1:0] item_value;
        logic [BYTE_W-1:0] payload_total;
    } t_res;

endpackage

// ----- rtl/plp_cfg.sv -----
// Configuration register file for the packet parser.
// Depends on plp_pkg.
module plp_cfg
    import plp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [ADDR_W-1:0] i_cfg_addr,
    input  logic [BYTE_W-1:0] i_cfg_wdata,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_first     <= RST_SYNC_FIRST;
            r_cfg.sync_second    <= RST_SYNC_SECOND;
            r_cfg.sync_third     <= RST_SYNC_THIRD;
            r_cfg.length_min     <= RST_LENGTH_MIN;
            r_cfg.length_max     <= RST_LENGTH_MAX;
            r_cfg.overhead_bytes <= RST_OVERHEAD;
        end else if (i_cfg_we) begin
            // indexes past the last register are dropped
            case (i_cfg_addr)
                REG_SYNC_FIRST:  r_cfg.sync_first     <= i_cfg_wdata;
                REG_SYNC_SECOND: r_cfg.sync_second    <= i_cfg_wdata;
                REG_SYNC_THIRD:  r_cfg.sync_third     <= i_cfg_wdata;
                REG_LENGTH_MIN:  r_cfg.length_min     <= i_cfg_wdata;
                REG_LENGTH_MAX:  r_cfg.length_max     <= i_cfg_wdata;
                REG_OVERHEAD:    r_cfg.overhead_bytes <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/plp_core.sv -----
// Per-byte parse state and result logic of the packet parser.
// Depends on plp_pkg; config comes from plp_cfg.
module plp_core
    import plp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [BYTE_W-1:0] i_byte,
    input  t_cfg              i_cfg,
    output t_res              o_res
);

    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [BYTE_W-1:0]  r_xor, n_xor;
    logic               r_err_rep, n_err_rep;
    logic [BYTE_W-1:0]  r_taken, n_taken;
    logic [BYTE_W-1:0]  r_expected, n_expected;

    logic [BYTE_W-1:0] xor_next;
    logic [BYTE_W-1:0] taken_inc;
    logic [BYTE_W-1:0] target;
    logic              fail;
    logic [BYTE_W-1:0] fail_code;
    t_res              res;

    assign xor_next  = r_xor ^ i_byte;
    assign taken_inc = r_taken + 8'd1;
    // short packets still carry one payload byte
    assign target    = (r_expected <= 8'd2) ? 8'd1 : (r_expected - 8'd1);

    always_comb begin
        n_phase    = r_phase;
        n_xor      = xor_next;
        n_err_rep  = r_err_rep;
        n_taken    = r_taken;
        n_expected = r_expected;
        fail       = 1'b0;
        fail_code  = ERR_SYNC1;
        res        = '0;

        unique case (r_phase)
            PH_SYNC1: begin
                if (i_byte != i_cfg.sync_first) begin
                    fail      = 1'b1;
                    fail_code = ERR_SYNC1;
                end else begin
                    n_phase = PH_SYNC2;
                end
            end
            PH_SYNC2: begin
                if (i_byte != i_cfg.sync_second) begin
                    fail      = 1'b1;
                    fail_code = ERR_SYNC2;
                end else begin
                    n_phase = PH_SYNC3;
                end
            end
            PH_SYNC3: begin
                if (i_byte != i_cfg.sync_third) begin
                    fail      = 1'b1;
                    fail_code = ERR_SYNC3;
                end else begin
                    n_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                if (i_byte < i_cfg.length_min || i_byte > i_cfg.length_max) begin
                    fail      = 1'b1;
                    fail_code = ERR_SIZE;
                end else begin
                    n_expected = i_byte - i_cfg.overhead_bytes;
                    n_taken    = '0;
                    n_phase    = PH_DATA;
                end
            end
            PH_DATA: begin
                n_taken = taken_inc;
                if (taken_inc >= target) begin
                    n_phase = PH_CHECK;
                end
                res.valid      = 1'b1;
                res.item_kind  = KIND_PAYLOAD;
                res.item_value = i_byte;
            end
            PH_CHECK: begin
                if (xor_next != '0) begin
                    fail      = 1'b1;
                    fail_code = ERR_CHECK;
                end else begin
                    n_err_rep         = 1'b0;
                    n_phase           = PH_SYNC1;
                    res.valid         = 1'b1;
                    res.item_kind     = KIND_GOOD;
                    res.payload_total = r_taken;
                end
            end
            default: begin
                // hunting, and the unused phase code: a sync byte restarts the checksum
                if (i_byte == i_cfg.sync_first) begin
                    n_xor   = i_byte;
                    n_phase = PH_SYNC2;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
        endcase

        if (fail) begin
            n_phase = PH_HUNT;
            if (!r_err_rep) begin
                n_err_rep      = 1'b1;
                res.valid      = 1'b1;
                res.item_kind  = KIND_ERROR;
                res.item_value = fail_code;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_SYNC1;
            r_xor      <= '0;
            r_err_rep  <= 1'b0;
            r_taken    <= '0;
            r_expected <= '0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_xor      <= n_xor;
            r_err_rep  <= n_err_rep;
            r_taken    <= n_taken;
            r_expected <= n_expected;
        end
    end

    assign o_res = res;

    a_err_sets_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && res.valid && res.item_kind == KIND_ERROR |=> r_err_rep)
        else $error("error beat did not set the reported flag");

    a_good_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && res.valid && res.item_kind == KIND_GOOD
        |=> r_phase == PH_SYNC1 && !r_err_rep)
        else $error("good end did not return to first sync phase");

    a_hunt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && r_phase == PH_HUNT |-> !res.valid)
        else $error("result produced while hunting");

endmodule

// ----- rtl/preamble_length_xor_packet_parser.sv -----
// An accepted byte passes the input register, one parse step and the output register, which holds its result beat.
// Throughput: one byte per cycle while the output register is not stalled.
// The input register holds a byte while the output register is stalled.
// Reset (i_rst_n low, synchronous) restores the register defaults, empties both
// registers and puts the parser in its first sync phase with a cleared checksum.
module preamble_length_xor_packet_parser
    import plp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // config write port
    input  logic              i_cfg_we,
    input  logic [ADDR_W-1:0] i_cfg_addr,
    input  logic [BYTE_W-1:0] i_cfg_wdata,
    // input stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [7:0] in_byte
    // result stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [15:0]       m_axis_tdata,   // [7:0] item_value, [15:8] payload_total
    output logic [1:0]        m_axis_tuser    // [1:0] item_kind
);

    t_cfg cfg;
    t_res res;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    t_res              r_out;
    logic              out_free;
    logic              step;

    plp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    assign out_free      = !r_out_valid || m_axis_tready;
    assign step          = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    plp_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    // a byte that yields nothing simply leaves the output register empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= res.valid;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res.valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.payload_total, r_out.item_value};
    assign m_axis_tuser  = r_out.item_kind;

endmodule

// ----- tb/tb_top.sv -----
// Self-checking bench for preamble_length_xor_packet_parser.
// It predicts the parser's payload, good-end and error beats and checks them
// against the result stream. Depends on plp_pkg and on the parser RTL.
module tb_top;
    import plp_pkg::*;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] value;
        logic [BYTE_W-1:0] total;
    } t_parse_item;

    typedef enum int {
        PKT_GOOD,
        PKT_BAD_SYNC1,
        PKT_BAD_SYNC2,
        PKT_BAD_SYNC3,
        PKT_BAD_SIZE,
        PKT_BAD_CHECK
    } t_pkt_flaw;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [ADDR_W-1:0] i_cfg_addr = '0;
    logic [BYTE_W-1:0] i_cfg_wdata = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata = '0;   // [7:0] in_byte
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [15:0]       m_axis_tdata;        // [7:0] item_value, [15:8] payload_total
    logic [1:0]        m_axis_tuser;        // [1:0] item_kind

    preamble_length_xor_packet_parser uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // parser shadow state
    t_cfg               cfg_m;
    logic [PHASE_W-1:0] phase_m;
    logic [7:0]         xor_m;
    logic               err_m;
    logic [7:0]         taken_m;
    logic [7:0]         due_m;

    t_parse_item        deframed_q[$];
    logic [7:0]         rx_bytes_q[$];
    t_parse_item        head_item;

    int unsigned bytes_queued = 0;
    int unsigned bytes_in = 0;
    int unsigned packet_bytes = 0;
    int unsigned mismatches = 0;
    int unsigned n_payload = 0;
    int unsigned n_good = 0;
    int unsigned n_err = 0;
    int unsigned n_settings = 1;
    bit          burst_tx = 1'b0;
    bit          burst_rx = 1'b0;
    int          tx_gap = 0;
    int          rx_stall = 0;
    logic        in_beat = 1'b0;
    logic        out_beat = 1'b0;

    task automatic parser_reset();
        cfg_m.sync_first     = RST_SYNC_FIRST;
        cfg_m.sync_second    = RST_SYNC_SECOND;
        cfg_m.sync_third     = RST_SYNC_THIRD;
        cfg_m.length_min     = RST_LENGTH_MIN;
        cfg_m.length_max     = RST_LENGTH_MAX;
        cfg_m.overhead_bytes = RST_OVERHEAD;
        phase_m = PH_SYNC1;
        xor_m   = '0;
        err_m   = 1'b0;
        taken_m = '0;
        due_m   = '0;
    endtask

    // failure: go hunting, report only the first error of a bad stretch
    task automatic flag_error(input logic [7:0] code);
        phase_m = PH_HUNT;
        if (!err_m) begin
            err_m = 1'b1;
            deframed_q.push_back('{KIND_ERROR, code, 8'd0});
        end
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        logic [7:0] last_idx;
        xor_m = xor_m ^ b;
        case (phase_m)
            PH_SYNC1: begin
                if (b != cfg_m.sync_first) flag_error(ERR_SYNC1);
                else phase_m = PH_SYNC2;
            end
            PH_SYNC2: begin
                if (b != cfg_m.sync_second) flag_error(ERR_SYNC2);
                else phase_m = PH_SYNC3;
            end
            PH_SYNC3: begin
                if (b != cfg_m.sync_third) flag_error(ERR_SYNC3);
                else phase_m = PH_LEN;
            end
            PH_LEN: begin
                if (b < cfg_m.length_min || b > cfg_m.length_max) begin
                    flag_error(ERR_SIZE);
                end else begin
                    due_m   = b - cfg_m.overhead_bytes;
                    taken_m = '0;
                    phase_m = PH_DATA;
                end
            end
            PH_DATA: begin
                taken_m  = taken_m + 8'd1;
                last_idx = (due_m <= 8'd2) ? 8'd1 : due_m - 8'd1;
                if (taken_m >= last_idx) phase_m = PH_CHECK;
                deframed_q.push_back('{KIND_PAYLOAD, b, 8'd0});
            end
            PH_CHECK: begin
                if (xor_m != 8'd0) begin
                    flag_error(ERR_CHECK);
                end else begin
                    err_m   = 1'b0;
                    phase_m = PH_SYNC1;
                    deframed_q.push_back('{KIND_GOOD, 8'd0, taken_m});
                end
            end
            default: begin
                // hunting: a first sync byte restarts the checksum
                if (b == cfg_m.sync_first) begin
                    xor_m   = b;
                    phase_m = PH_SYNC2;
                end else begin
                    phase_m = PH_HUNT;
                end
            end
        endcase
    endtask

    // handshake sampling, prediction and result checking
    always @(posedge i_clk) begin
        in_beat  <= i_rst_n && s_axis_tvalid && s_axis_tready;
        out_beat <= i_rst_n && m_axis_tvalid && m_axis_tready;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (deframed_q.size() == 0) begin
                $error("result beat with nothing due: kind %0d value %0d total %0d",
                       m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[15:8]);
                mismatches++;
            end else begin
                head_item = deframed_q.pop_front();
                if (m_axis_tuser !== head_item.kind) begin
                    $error("item_kind: expected %0d, got %0d", head_item.kind, m_axis_tuser);
                    mismatches++;
                end
                if (m_axis_tdata[7:0] !== head_item.value) begin
                    $error("item_value: expected %0d, got %0d",
                           head_item.value, m_axis_tdata[7:0]);
                    mismatches++;
                end
                if (m_axis_tdata[15:8] !== head_item.total) begin
                    $error("payload_total: expected %0d, got %0d",
                           head_item.total, m_axis_tdata[15:8]);
                    mismatches++;
                end
                case (head_item.kind)
                    KIND_PAYLOAD: n_payload++;
                    KIND_GOOD:    n_good++;
                    default:      n_err++;
                endcase
            end
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            deframe_byte(s_axis_tdata);
            bytes_in++;
        end
    end

    // byte driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_beat) begin
            if (tx_gap > 0) begin
                s_axis_tvalid <= 1'b0;
                tx_gap        <= tx_gap - 1;
            end else if (rx_bytes_q.size() > 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= rx_bytes_q.pop_front();
                tx_gap        <= burst_tx ? 0 : $urandom_range(0, 16);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result sink: a fresh stall is drawn after every beat
    always @(negedge i_clk) begin : rx_side
        int stall;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            stall = out_beat ? (burst_rx ? 0 : $urandom_range(0, 16)) : rx_stall;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                rx_stall      <= stall - 1;
            end else begin
                m_axis_tready <= 1'b1;
                rx_stall      <= 0;
            end
        end
    end

    function automatic t_cfg make_cfg(input logic [7:0] s1, s2, s3, mn, mx, ov);
        t_cfg c;
        c.sync_first     = s1;
        c.sync_second    = s2;
        c.sync_third     = s3;
        c.length_min     = mn;
        c.length_max     = mx;
        c.overhead_bytes = ov;
        return c;
    endfunction

    task automatic write_reg(input logic [ADDR_W-1:0] idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            REG_SYNC_FIRST:  cfg_m.sync_first     = val;
            REG_SYNC_SECOND: cfg_m.sync_second    = val;
            REG_SYNC_THIRD:  cfg_m.sync_third     = val;
            REG_LENGTH_MIN:  cfg_m.length_min     = val;
            REG_LENGTH_MAX:  cfg_m.length_max     = val;
            REG_OVERHEAD:    cfg_m.overhead_bytes = val;
            default: ;
        endcase
    endtask

    task automatic set_config(input t_cfg c);
        write_reg(REG_SYNC_FIRST,  c.sync_first);
        write_reg(REG_SYNC_SECOND, c.sync_second);
        write_reg(REG_SYNC_THIRD,  c.sync_third);
        write_reg(REG_LENGTH_MIN,  c.length_min);
        write_reg(REG_LENGTH_MAX,  c.length_max);
        write_reg(REG_OVERHEAD,    c.overhead_bytes);
        n_settings++;
    endtask

    // hold the sender until every byte is in and every result is out,
    // then cover bytes still in the pipe that make no result
    task automatic drain();
        do @(negedge i_clk);
        while (bytes_in != bytes_queued || deframed_q.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic push_byte(input logic [7:0] b);
        rx_bytes_q.push_back(b);
        bytes_queued++;
    endtask

    task automatic send_packet(input t_pkt_flaw flaw);
        logic [7:0] len, e, acc, b;
        int         n, tries;
        for (tries = 0; tries < 30; tries++) begin
            if (tries < 20 && $urandom_range(0, 39) != 0)
                len = 8'(cfg_m.overhead_bytes + $urandom_range(0, 13));
            else
                len = 8'($urandom_range(cfg_m.length_max, cfg_m.length_min));
            if (len >= cfg_m.length_min && len <= cfg_m.length_max) break;
        end
        if (flaw == PKT_BAD_SIZE) begin
            if (cfg_m.length_min > 0 && (cfg_m.length_max == 8'd255 || $urandom_range(0, 1)))
                len = 8'($urandom_range(cfg_m.length_min - 1, 0));
            else if (cfg_m.length_max < 8'd255)
                len = 8'($urandom_range(255, cfg_m.length_max + 1));
            else
                flaw = PKT_BAD_CHECK;   // full window: no length can fail
        end
        e = len - cfg_m.overhead_bytes;
        n = (e <= 8'd2) ? 1 : int'(e) - 1;
        if (flaw != PKT_GOOD && flaw != PKT_BAD_CHECK && n > 12) n = $urandom_range(0, 12);
        acc = '0;
        for (int i = 0; i < 4 + n; i++) begin
            case (i)
                0:       b = cfg_m.sync_first;
                1:       b = cfg_m.sync_second;
                2:       b = cfg_m.sync_third;
                3:       b = len;
                default: b = 8'($urandom_range(0, 255));
            endcase
            if ((i == 0 && flaw == PKT_BAD_SYNC1) || (i == 1 && flaw == PKT_BAD_SYNC2) ||
                (i == 2 && flaw == PKT_BAD_SYNC3))
                b = b ^ 8'($urandom_range(1, 255));
            acc = acc ^ b;
            push_byte(b);
        end
        if (flaw == PKT_BAD_CHECK) acc = acc ^ (8'd1 << $urandom_range(0, 7));
        push_byte(acc);
        packet_bytes += 5 + n;
    endtask

    initial begin : stimulus
        t_cfg       plan [7];
        int         budget [7];
        logic [7:0] mn;
        int         r;

        parser_reset();
        plan[0]   = make_cfg(RST_SYNC_FIRST, RST_SYNC_SECOND, RST_SYNC_THIRD,
                             RST_LENGTH_MIN, RST_LENGTH_MAX, RST_OVERHEAD);
        budget[0] = 190;
        plan[1]   = make_cfg(8'h00, 8'h00, 8'h00, 8'd0, 8'd255, 8'd0);
        budget[1] = 200;
        plan[2]   = make_cfg(8'hFF, 8'hFF, 8'hFF, 8'd255, 8'd255, 8'd255);
        budget[2] = 200;
        // empty length window: every length byte is a size error
        plan[3]   = make_cfg(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)), 8'd200, 8'd100,
                             8'($urandom_range(0, 255)));
        budget[3] = 60;
        plan[4]   = make_cfg(8'h7E, 8'h7E, 8'h7E, 8'd3, 8'd10, 8'd2);
        budget[4] = 200;
        mn        = 8'($urandom_range(0, 20));
        plan[5]   = make_cfg(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)), mn, 8'($urandom_range(255, mn)),
                             8'($urandom_range(0, 255)));
        budget[5] = 200;
        plan[6]   = plan[0];
        budget[6] = 200;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, default registers: good packet with extreme payload bytes
        push_byte(8'hAA); push_byte(8'h55); push_byte(8'hCC); push_byte(8'h08);
        push_byte(8'h00); push_byte(8'hFF); push_byte(8'h5A); push_byte(8'h9E);
        // bad first sync byte, then noise while hunting
        push_byte(8'h00); push_byte(8'hFF);
        // packet found by the hunt, ends good and re-arms error reporting
        push_byte(8'hAA); push_byte(8'h55); push_byte(8'hCC); push_byte(8'h08);
        push_byte(8'hFF); push_byte(8'h80); push_byte(8'h01); push_byte(8'h45);
        // second sync error reported, then a third sync error suppressed
        push_byte(8'hAA); push_byte(8'h00);
        push_byte(8'hAA); push_byte(8'h55); push_byte(8'h00);

        for (int p = 0; p < 7; p++) begin
            if (p > 0) begin
                drain();
                set_config(plan[p]);
            end
            burst_tx     = ($urandom_range(0, 2) == 0);
            burst_rx     = ($urandom_range(0, 2) == 0);
            packet_bytes = 0;
            while (packet_bytes < budget[p]) begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    send_packet(PKT_GOOD);
                else if (r < 88)
                    send_packet(t_pkt_flaw'($urandom_range(PKT_BAD_SYNC1, PKT_BAD_CHECK)));
                else
                    repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 24) == 0) begin
                    drain();
                    burst_tx = ($urandom_range(0, 2) == 0);
                    burst_rx = ($urandom_range(0, 2) == 0);
                end
            end
        end
        drain();

        $display("Covered %0d input beats over %0d register settings:", bytes_in, n_settings);
        $display("  %0d payload beats, %0d good packet ends, %0d error reports",
                 n_payload, n_good, n_err);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #10_000_000;
        $error("run did not finish in time: %0d results still due", deframed_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
